FILE: design/pasu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pasu_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int POS_W   = 7;
  localparam int ST_W    = 3;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_DISPLAY = 2'd0,
    OP_INSERT  = 2'd1,
    OP_DELETE  = 2'd2,
    OP_SEARCH  = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef struct packed {
    op_e                       op;
    logic signed [DATA_W-1:0]  value;
    logic        [POS_W-1:0]   position;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/positional_array_insert_delete_search_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered store of up to 64 signed 32-bit values held in a row of shifting
// cells, with a two-entry command queue in front of a one-command-at-a-time
// sequencer. Insert and delete complete straight from idle, search compares
// then priority encodes, and display emits the stored entries in turn, one
// each time the output is free (an empty store reports empty at once),
// while the cell row rotates once past its head. Results leave through an
// output register, so a stalled result does not stop the queue from taking
// new transactions until both queue entries are taken. Store contents are
// not cleared at reset; only entries below the fill count are ever shown.
module positional_array_insert_delete_search_unit import pasu_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                opcode_i,
  input  logic signed [DATA_W-1:0]  value_i,
  input  logic [POS_W-1:0]          position_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ST_W-1:0]           status_o,
  output logic signed [DATA_W-1:0]  data_o,
  output logic [IDX_W-1:0]          index_o,
  output logic                      last_o
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  pasu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  pasu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .index_o     (index_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

FILE: design/pasu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pasu_front import pasu_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                opcode_i,
  input  logic signed [DATA_W-1:0]  value_i,
  input  logic [POS_W-1:0]          position_i,
  output logic                      cmd_valid_o,
  output cmd_t                      cmd_o,
  input  logic                      cmd_pop_i
);

  cmd_t              queue_q [QDEPTH];
  logic [QPTR_W-1:0] head_q, head_d;
  logic [QPTR_W-1:0] tail_q, tail_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              push;
  logic              pop;
  cmd_t              cmd_in;

  // decode the raw transaction into a command word
  always_comb begin
    cmd_in.op       = op_e'(opcode_i);
    cmd_in.value    = value_i;
    cmd_in.position = position_i;
  end

  assign in_stall_o  = (fill_q == QCNT_W'(QDEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = queue_q[head_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (push) begin
      tail_d = (tail_q == QPTR_W'(QDEPTH - 1)) ? '0 : tail_q + QPTR_W'(1);
    end
    if (pop) begin
      head_d = (head_q == QPTR_W'(QDEPTH - 1)) ? '0 : head_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + QCNT_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[tail_q] <= cmd_in;
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= QCNT_W'(QDEPTH))
    else $error("command queue overfilled");
  a_fill_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (fill_q == $past(fill_q) + QCNT_W'(1)))
    else $error("queue fill did not follow push");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0 || fill_q == QCNT_W'(QDEPTH)) |-> (head_q == tail_q))
    else $error("queue pointers out of step with fill");
`endif

endmodule

`default_nettype wire

FILE: design/pasu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pasu_back import pasu_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  cmd_t                      cmd_i,
  output logic                      cmd_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ST_W-1:0]           status_o,
  output logic signed [DATA_W-1:0]  data_o,
  output logic [IDX_W-1:0]          index_o,
  output logic                      last_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DISP = 3'b010,
    S_SRCH = 3'b100
  } state_e;

  state_e                   state_q, state_d;
  logic signed [DATA_W-1:0] cells_q [DEPTH];
  logic signed [DATA_W-1:0] cells_d [DEPTH];
  logic signed [DATA_W-1:0] up_cells [DEPTH];
  logic signed [DATA_W-1:0] dn_cells [DEPTH];
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [IDX_W-1:0]         disp_q, disp_d;
  logic [DEPTH-1:0]         match_q, match_d;
  logic                     out_valid_q, out_valid_d;
  status_e                  status_q, res_status;
  logic signed [DATA_W-1:0] data_q, res_data;
  logic [IDX_W-1:0]         index_q, res_index;
  logic                     last_q, res_last;
  logic                     res_load;
  logic                     out_free;
  logic                     disp_last;
  logic [IDX_W-1:0]         hit_idx;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign disp_last = (CNT_W'(disp_q) + CNT_W'(1)) == cnt_q;

  // neighbor views of the cell row: each cell sees its lower and upper neighbor
  always_comb begin
    up_cells[0]       = cells_q[0];
    dn_cells[DEPTH-1] = cells_q[DEPTH-1];
    for (int i = 1; i < DEPTH; i++) begin
      up_cells[i]   = cells_q[i-1];
      dn_cells[i-1] = cells_q[i];
    end
  end

  // lowest matching cell wins
  always_comb begin
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cells_d     = cells_q;
    cnt_d       = cnt_q;
    disp_d      = disp_q;
    match_d     = match_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_pop_o   = 1'b0;
    res_load    = 1'b0;
    res_status  = ST_OK;
    res_data    = '0;
    res_index   = '0;
    res_last    = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_DISPLAY: begin
              if (cnt_q == '0) begin
                res_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                disp_d  = '0;
                state_d = S_DISP;
              end
            end
            OP_INSERT: begin
              res_load = 1'b1;
              if (cnt_q == CNT_W'(DEPTH)) begin
                res_status = ST_FULL;
              end else if (cmd_i.position > cnt_q) begin
                res_status = ST_BADPOS;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (CNT_W'(i) == cmd_i.position) begin
                    cells_d[i] = cmd_i.value;
                  end else if (CNT_W'(i) > cmd_i.position && CNT_W'(i) <= cnt_q) begin
                    cells_d[i] = up_cells[i];
                  end
                end
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              res_load = 1'b1;
              if (cnt_q == '0) begin
                res_status = ST_EMPTY;
              end else if (cmd_i.position >= cnt_q) begin
                res_status = ST_BADPOS;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (CNT_W'(i) >= cmd_i.position && (CNT_W'(i) + CNT_W'(1)) < cnt_q) begin
                    cells_d[i] = dn_cells[i];
                  end
                end
                cnt_d = cnt_q - CNT_W'(1);
              end
            end
            OP_SEARCH: begin
              for (int i = 0; i < DEPTH; i++) begin
                match_d[i] = (cells_q[i] == cmd_i.value) && (CNT_W'(i) < cnt_q);
              end
              state_d = S_SRCH;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_DISP: begin
        // emit the head cell, then rotate the filled part by one
        if (out_free) begin
          res_load  = 1'b1;
          res_data  = cells_q[0];
          res_index = disp_q;
          res_last  = disp_last;
          for (int i = 0; i < DEPTH; i++) begin
            if ((CNT_W'(i) + CNT_W'(1)) < cnt_q) begin
              cells_d[i] = dn_cells[i];
            end else if ((CNT_W'(i) + CNT_W'(1)) == cnt_q) begin
              cells_d[i] = cells_q[0];
            end
          end
          disp_d = disp_q + IDX_W'(1);
          if (disp_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_SRCH: begin
        if (out_free) begin
          res_load = 1'b1;
          if (|match_q) begin
            res_index = hit_idx;
          end else begin
            res_status = ST_NOTFOUND;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
    disp_q  <= disp_d;
    match_q <= match_d;
    if (res_load) begin
      status_q <= res_status;
      data_q   <= res_data;
      index_q  <= res_index;
      last_q   <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign index_o     = index_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == $past(cnt_q) + CNT_W'(1) || cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("fill count moved by more than one");
  a_disp_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DISP) |-> (cnt_q != '0 && CNT_W'(disp_q) < cnt_q))
    else $error("display index past fill count");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == S_IDLE && cmd_valid_i))
    else $error("command taken while busy");
`endif

endmodule

`default_nettype wire
